>>> hw/rtl/eai_pkg.sv
// Package for the Ethernet ARP/IPv4 ingress block.
// Constants, the scan-to-emit job type and the ARP reply byte table.
// No dependencies.
package eai_pkg;

	localparam int unsigned HdrBytes = 42;
	localparam logic [16:0] CountMax = 17'd65549;
	localparam logic [16:0] LenEth = 17'd14;
	localparam logic [16:0] LenIpv4 = 17'd34;
	localparam logic [16:0] LenArp = 17'd42;
	localparam logic [15:0] EtypeArp = 16'h0806;
	localparam logic [15:0] EtypeIpv4 = 16'h0800;
	localparam logic [5:0] IhlMin = 6'd20;
	localparam logic [5:0] ScanFirst = 6'd6;
	localparam logic [5:0] ScanLast = 6'd41;
	localparam logic [5:0] ReplyLastIdx = 6'd42;

	localparam logic [1:0] VerdictMalformed = 2'd0;
	localparam logic [1:0] VerdictIgnored = 2'd1;
	localparam logic [1:0] VerdictIpv4 = 2'd2;

	localparam logic [1:0] CfgOurMac = 2'd0;
	localparam logic [1:0] CfgOurIp = 2'd1;
	localparam logic [1:0] CfgPeerIp = 2'd2;

	typedef struct packed {
		logic [1:0] verdict;
		logic [15:0] ip_length;
		logic reply;
		logic [47:0] sha;
		logic [31:0] spa;
		logic [47:0] peer_mac;
		logic peer_known;
	} job_t;

	function automatic logic [7:0] reply_byte(input logic [5:0] i, input logic [47:0] sha,
			input logic [47:0] mac, input logic [31:0] ip, input logic [31:0] spa);
		logic [7:0] b;
		b = 8'h00;
		if (i < 6'd6) begin
			b = sha[8*(5-i) +: 8];
		end else if (i < 6'd12) begin
			b = mac[8*(11-i) +: 8];
		end else if (i < 6'd22) begin
			unique case (i)
				6'd12: b = 8'h08;
				6'd13: b = 8'h06;
				6'd15: b = 8'h01;
				6'd16: b = 8'h08;
				6'd18: b = 8'h06;
				6'd19: b = 8'h04;
				6'd21: b = 8'h02;
				default: b = 8'h00;
			endcase
		end else if (i < 6'd28) begin
			b = mac[8*(27-i) +: 8];
		end else if (i < 6'd32) begin
			b = ip[8*(31-i) +: 8];
		end else if (i < 6'd38) begin
			b = sha[8*(37-i) +: 8];
		end else if (i < 6'd42) begin
			b = spa[8*(41-i) +: 8];
		end
		return b;
	endfunction

endpackage

>>> hw/rtl/eai_scan.sv
// Frame intake: header memory, byte counter, header scan and frame verdict.
// Holds the learned peer MAC. Depends on eai_pkg.
module eai_scan (
	input logic clk,
	input logic arst_n,
	input logic [7:0] frame_byte,
	input logic last_byte,
	input logic in_valid,
	output logic in_ready,
	input logic [31:0] our_ip,
	input logic [31:0] peer_ip,
	output logic job_valid,
	input logic job_ready,
	output eai_pkg::job_t job
);
	import eai_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DECIDE = 2'd3;

	logic [1:0] state_q;
	logic [16:0] cnt_q, cnt_nx, len_q;
	logic [7:0] mem [HdrBytes];
	logic [7:0] rdata_s1;
	logic [5:0] raddr_q, raddr_s1;
	logic rvld_s1;
	logic [47:0] src_q, sha_q, peer_mac_q;
	logic [15:0] etype_q;
	logic [63:0] hdr_q;
	logic [31:0] spa_q, tpa_q;
	logic peer_known_q;
	logic acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc = in_valid && in_ready;
	assign cnt_nx = (cnt_q < CountMax) ? cnt_q + 17'd1 : cnt_q;

	always_ff @(posedge clk) begin
		if (acc && cnt_q < LenArp) begin
			mem[cnt_q[5:0]] <= frame_byte;
		end
		rdata_s1 <= mem[raddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			len_q <= '0;
			raddr_q <= ScanFirst;
			raddr_s1 <= ScanFirst;
			rvld_s1 <= 1'b0;
			peer_mac_q <= '0;
			peer_known_q <= 1'b0;
		end else begin
			rvld_s1 <= 1'b0;
			raddr_s1 <= raddr_q;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (last_byte) begin
							cnt_q <= '0;
							len_q <= cnt_nx;
							raddr_q <= ScanFirst;
							state_q <= S_SCAN;
						end else begin
							cnt_q <= cnt_nx;
						end
					end
				end
				S_SCAN: begin
					rvld_s1 <= 1'b1;
					if (raddr_q == ScanLast) begin
						state_q <= S_DRAIN;
					end else begin
						raddr_q <= raddr_q + 6'd1;
					end
				end
				S_DRAIN: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (job_ready) begin
						peer_mac_q <= job.peer_mac;
						peer_known_q <= job.peer_known;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rvld_s1) begin
			priority if (raddr_s1 < 6'd12) src_q <= {src_q[39:0], rdata_s1};
			else if (raddr_s1 < 6'd14) etype_q <= {etype_q[7:0], rdata_s1};
			else if (raddr_s1 < 6'd22) hdr_q <= {hdr_q[55:0], rdata_s1};
			else if (raddr_s1 < 6'd28) sha_q <= {sha_q[39:0], rdata_s1};
			else if (raddr_s1 < 6'd32) spa_q <= {spa_q[23:0], rdata_s1};
			else if (raddr_s1 < 6'd38) ;
			else tpa_q <= {tpa_q[23:0], rdata_s1};
		end
	end

	logic [7:0] h14, h18, h19;
	logic [15:0] h1415, h1617, oper;
	logic [5:0] ihl;
	logic arp_ok, arp_learn, ip_bad;
	logic [16:0] room;

	always_comb begin
		h14 = hdr_q[63:56];
		h1415 = hdr_q[63:48];
		h1617 = hdr_q[47:32];
		h18 = hdr_q[31:24];
		h19 = hdr_q[23:16];
		oper = hdr_q[15:0];
		ihl = {h14[3:0], 2'b00};
		room = len_q - LenEth;
		arp_ok = (h1415 == 16'd1) && (h1617 == EtypeIpv4) && (h18 == 8'd6) &&
			(h19 == 8'd4) && (sha_q == src_q) && !sha_q[40];
		arp_learn = arp_ok && (spa_q == peer_ip);
		ip_bad = (h14[7:4] != 4'd4) || (ihl < IhlMin) || (h1617 < {10'd0, ihl}) ||
			({1'b0, h1617} > room) || src_q[40];

		job.verdict = VerdictIgnored;
		job.ip_length = '0;
		job.reply = 1'b0;
		job.sha = sha_q;
		job.spa = spa_q;
		job.peer_mac = peer_mac_q;
		job.peer_known = peer_known_q;
		if (len_q < LenEth) begin
			job.verdict = VerdictMalformed;
		end else if (etype_q == EtypeArp) begin
			if (len_q < LenArp) begin
				job.verdict = VerdictMalformed;
			end else if (arp_ok) begin
				if (arp_learn) begin
					job.peer_mac = sha_q;
					job.peer_known = 1'b1;
				end
				job.reply = (oper == 16'd1) && (tpa_q == our_ip);
			end
		end else if (etype_q == EtypeIpv4) begin
			if (len_q < LenIpv4 || ip_bad) begin
				job.verdict = VerdictMalformed;
			end else begin
				job.verdict = VerdictIpv4;
				job.ip_length = h1617;
				job.peer_mac = src_q;
				job.peer_known = 1'b1;
			end
		end
	end

	assign job_valid = (state_q == S_DECIDE);

`ifndef ASSERT_OFF
	a_last_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last_byte |=> state_q == S_SCAN && cnt_q == '0)
		else $error("scan did not start after frame end");
	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CountMax)
		else $error("byte count beyond saturation");
	a_scan_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> raddr_q >= ScanFirst && raddr_q <= ScanLast)
		else $error("scan address out of range");
	a_decide_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |=> state_q == S_DECIDE && $past(rvld_s1))
		else $error("decision before last header byte captured");
`endif
endmodule

>>> hw/rtl/eai_emit.sv
// Result emitter: verdict item, then the 42-byte ARP reply when due.
// Output register with valid/ready. Depends on eai_pkg.
module eai_emit (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_ready,
	input eai_pkg::job_t job,
	input logic [47:0] our_mac,
	input logic [31:0] our_ip,
	output logic out_valid,
	input logic out_ready,
	output logic out_kind,
	output logic [1:0] verdict,
	output logic [15:0] ip_length,
	output logic [7:0] out_byte,
	output logic out_last,
	output logic [47:0] learned_mac,
	output logic peer_valid
);
	import eai_pkg::*;

	logic busy_q;
	logic [5:0] idx_q;
	job_t job_q;
	logic adv, last;
	logic [5:0] ri;

	assign job_ready = !busy_q;
	assign adv = !out_valid || out_ready;
	assign last = job_q.reply ? (idx_q == ReplyLastIdx) : 1'b1;
	assign ri = idx_q - 6'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (busy_q && adv) begin
				out_valid <= 1'b1;
				if (last) busy_q <= 1'b0;
				idx_q <= idx_q + 6'd1;
			end else if (adv) begin
				out_valid <= 1'b0;
			end
			if (job_valid && !busy_q) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_valid && !busy_q) job_q <= job;
		if (busy_q && adv) begin
			out_kind <= (idx_q != 6'd0);
			verdict <= (idx_q == 6'd0) ? job_q.verdict : VerdictMalformed;
			ip_length <= (idx_q == 6'd0) ? job_q.ip_length : 16'd0;
			out_byte <= (idx_q == 6'd0) ? 8'd0 :
				reply_byte(ri, job_q.sha, our_mac, our_ip, job_q.spa);
			out_last <= last;
			learned_mac <= job_q.peer_mac;
			peer_valid <= job_q.peer_known;
		end
	end
endmodule

>>> hw/rtl/ethernet_arp_ipv4_ingress.sv
// Top level of the Ethernet ARP/IPv4 ingress block: configuration registers,
// frame intake and result emitter. Depends on eai_pkg, eai_scan, eai_emit.
//
// Frame bytes transfer at one per cycle while in_ready is high; the first 42
// are kept in a synchronous memory with separate write and read ports. After
// the last byte the block reads bytes 6..41 back one per cycle, then issues
// a verdict item and, for an ARP request to our_ip, 42 reply bytes. Input is
// stalled from frame end until the verdict is handed to the emitter; the
// emitter can still be draining reply bytes while the next frame streams in.
module ethernet_arp_ipv4_ingress (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [47:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] frame_byte,
	input logic last_byte,
	output logic out_valid,
	input logic out_ready,
	output logic out_kind,
	output logic [1:0] verdict,
	output logic [15:0] ip_length,
	output logic [7:0] out_byte,
	output logic out_last,
	output logic [47:0] learned_mac,
	output logic peer_valid
);
	import eai_pkg::*;

	logic [47:0] our_mac_q;
	logic [31:0] our_ip_q, peer_ip_q;
	logic job_valid, job_ready;
	job_t job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			our_mac_q <= '0;
			our_ip_q <= '0;
			peer_ip_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgOurMac: our_mac_q <= cfg_data;
				CfgOurIp: our_ip_q <= cfg_data[31:0];
				CfgPeerIp: peer_ip_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	eai_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.frame_byte(frame_byte),
		.last_byte(last_byte),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.our_ip(our_ip_q),
		.peer_ip(peer_ip_q),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job(job)
	);

	eai_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job(job),
		.our_mac(our_mac_q),
		.our_ip(our_ip_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_kind(out_kind),
		.verdict(verdict),
		.ip_length(ip_length),
		.out_byte(out_byte),
		.out_last(out_last),
		.learned_mac(learned_mac),
		.peer_valid(peer_valid)
	);
endmodule
